// ===== rtl/swg_pkg.sv =====
// swg_pkg: widths, register map, codes and shared types of the swipe gesture classifier
// no dependencies; compiled before every other file of the block

package swg_pkg;

	// ratio format: signed, RATIO_FRAC_BITS fractional bits
	localparam int RATIO_FRAC_BITS = 15;
	localparam int COUNT_W         = 8;
	localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
	localparam int DELTA_W         = RATIO_W + 1;
	localparam int SWIPE_TH_W      = 16;
	localparam int CMP_W           = (DELTA_W > SWIPE_TH_W) ? DELTA_W : SWIPE_TH_W;
	localparam int DEN_W           = COUNT_W + 1;
	localparam int SUM_W           = COUNT_W + 2;
	localparam int DIV_CNT_W       = $clog2(RATIO_FRAC_BITS);

	// register widths and reset values
	localparam int NEAR_TH_W  = 8;
	localparam int TURNS_W    = 2;
	localparam int STRENGTH_W = 10;
	localparam logic [NEAR_TH_W-1:0]  NEAR_TH_RST   = NEAR_TH_W'(50);
	localparam logic [TURNS_W-1:0]    TURNS_RST     = TURNS_W'(0);
	localparam logic [SWIPE_TH_W-1:0] SWIPE_TH_RST  = SWIPE_TH_W'(4260);
	localparam logic [STRENGTH_W-1:0] STRENGTH_RST  = STRENGTH_W'(40);

	// far limit = threshold*3/5 as (threshold*3)*205 >> 10, exact below 1024
	localparam int FAR_X3_W   = NEAR_TH_W + 2;
	localparam int FAR_MUL    = 205;
	localparam int FAR_SHIFT  = 10;
	localparam int FAR_PROD_W = FAR_X3_W + 8;

	// apb register map
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;
	localparam logic [REG_IDX_W-1:0] REG_NEAR_LEVEL      = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_QUARTER_TURNS   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SWIPE_THRESHOLD = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MIN_STRENGTH    = 2'd3;

	// action codes
	localparam logic [1:0] ACT_PROX    = 2'd0;
	localparam logic [1:0] ACT_DATASET = 2'd1;
	localparam logic [1:0] ACT_IDLE    = 2'd2;

	// swipe codes
	localparam logic [1:0] SW_UP    = 2'd0;
	localparam logic [1:0] SW_DOWN  = 2'd1;
	localparam logic [1:0] SW_LEFT  = 2'd2;
	localparam logic [1:0] SW_RIGHT = 2'd3;
	localparam logic [1:0] PROX_SWIPE = SW_UP;

	// event kinds
	localparam logic KIND_PROX    = 1'b0;
	localparam logic KIND_GESTURE = 1'b1;

	typedef logic signed [RATIO_W-1:0] ratio_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [COUNT_W-1:0] proximity;
		logic [COUNT_W-1:0] up_count;
		logic [COUNT_W-1:0] down_count;
		logic [COUNT_W-1:0] left_count;
		logic [COUNT_W-1:0] right_count;
	} swg_item_t;

	typedef struct packed {
		logic       event_kind;
		logic       is_near;
		logic [1:0] swipe;
	} swg_result_t;

	typedef struct packed {
		logic [NEAR_TH_W-1:0]  near_level;
		logic [TURNS_W-1:0]    quarter_turns;
		logic [SWIPE_TH_W-1:0] swipe_threshold;
		logic [STRENGTH_W-1:0] min_strength;
	} swg_cfg_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic sel_h;
		logic save_v;
		logic commit;
		logic prox_apply;
		logic end_apply;
	} swg_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       faint;
		logic       prox_change;
		logic       run_active;
		logic       swipe_hit;
		logic       slot_free;
		logic       div_done;
	} swg_status_t;

	// one clockwise quarter turn per step: up->right->down->left->up
	function automatic logic [1:0] swg_rotate(input logic [1:0] g, input logic [TURNS_W-1:0] turns);
		logic [1:0] r;
		r = g;
		for (int k = 0; k < 3; k++) begin
			if (k < int'(turns)) begin
				case (r)
					SW_UP:    r = SW_RIGHT;
					SW_DOWN:  r = SW_LEFT;
					SW_LEFT:  r = SW_UP;
					SW_RIGHT: r = SW_DOWN;
					default:  r = SW_UP;
				endcase
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/swg_item_if.sv =====
// swg_item_if: valid/ready channel carrying one input word of the classifier
// depends on swg_pkg

interface swg_item_if;
	import swg_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [COUNT_W-1:0] proximity;
	logic [COUNT_W-1:0] up_count;
	logic [COUNT_W-1:0] down_count;
	logic [COUNT_W-1:0] left_count;
	logic [COUNT_W-1:0] right_count;

	modport source (
		output valid, action, proximity, up_count, down_count, left_count, right_count,
		input  ready
	);

	modport sink (
		input  valid, action, proximity, up_count, down_count, left_count, right_count,
		output ready
	);
endinterface

// ===== rtl/swg_result_if.sv =====
// swg_result_if: valid/ready channel carrying one result word of the classifier
// no dependencies

interface swg_result_if;
	logic       valid;
	logic       ready;
	logic       event_kind;
	logic       is_near;
	logic [1:0] swipe;

	modport source (
		output valid, event_kind, is_near, swipe,
		input  ready
	);

	modport sink (
		input  valid, event_kind, is_near, swipe,
		output ready
	);
endinterface

// ===== rtl/swg_div.sv =====
// swg_div: bit-serial restoring divider for one balance ratio (a-b)*2^F/(a+b+1)
// one quotient bit per cycle, truncated toward zero; depends on swg_pkg

module swg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [swg_pkg::COUNT_W-1:0] a,
	input  logic [swg_pkg::COUNT_W-1:0] b,
	output logic                        done,
	output swg_pkg::ratio_t             quot
);
	import swg_pkg::*;

	logic                       busy_q;
	logic                       done_q;
	logic [DIV_CNT_W-1:0]       cnt_q;
	logic [DEN_W-1:0]           rem_q;
	logic [DEN_W-1:0]           den_q;
	logic [RATIO_FRAC_BITS-1:0] quo_q;
	logic                       neg_q;

	logic [DEN_W:0]             trial;
	logic [DEN_W:0]             diff;
	logic                       fits;
	logic [COUNT_W-1:0]         mag_ab;
	logic [RATIO_W-1:0]         quo_ext;

	assign trial   = {rem_q, 1'b0};
	assign diff    = trial - {1'b0, den_q};
	assign fits    = trial >= {1'b0, den_q};
	assign mag_ab  = (a >= b) ? (a - b) : (b - a);
	assign quo_ext = {1'b0, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(RATIO_FRAC_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(mag_ab);
			den_q <= DEN_W'(a) + DEN_W'(b) + DEN_W'(1);
			neg_q <= a < b;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[RATIO_FRAC_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? ratio_t'(-quo_ext) : ratio_t'(quo_ext);
endmodule

// ===== rtl/swg_datapath.sv =====
// swg_datapath: word register, hysteresis, run state, ratio divider and result register
// driven by swg_ctrl commands; depends on swg_pkg and swg_div

module swg_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swg_pkg::swg_cfg_t    cfg,
	input  swg_pkg::swg_item_t   item_in,
	input  swg_pkg::swg_cmd_t    cmd,
	input  logic                 res_ready,
	output logic                 res_valid,
	output swg_pkg::swg_result_t res,
	output swg_pkg::swg_status_t status
);
	import swg_pkg::*;

	swg_item_t   item_q;
	logic        near_q;
	logic        run_q;
	logic        first_seen_q;
	ratio_t      first_v_q;
	ratio_t      first_h_q;
	ratio_t      last_v_q;
	ratio_t      last_h_q;
	ratio_t      v_q;
	logic        res_valid_q;
	swg_result_t res_q;

	logic [SUM_W-1:0]      sum;
	logic [FAR_X3_W-1:0]   th_x3;
	logic [FAR_PROD_W-1:0] far_prod;
	logic [NEAR_TH_W-1:0]  far_limit;
	logic                  prox_change;

	logic signed [DELTA_W-1:0] dv;
	logic signed [DELTA_W-1:0] dh;
	logic [CMP_W-1:0]          mv;
	logic [CMP_W-1:0]          mh;
	logic [CMP_W-1:0]          th;
	logic                      hit;
	logic [1:0]                gest;
	logic [1:0]                gest_rot;

	logic [COUNT_W-1:0] div_a;
	logic [COUNT_W-1:0] div_b;
	logic               div_done;
	ratio_t             div_quot;
	logic               push;

	// far limit and hysteresis
	assign th_x3       = {1'b0, cfg.near_level, 1'b0} + FAR_X3_W'(cfg.near_level);
	assign far_prod    = FAR_PROD_W'(th_x3) * FAR_PROD_W'(FAR_MUL);
	assign far_limit   = far_prod[FAR_SHIFT +: NEAR_TH_W];
	assign prox_change = (!near_q && item_q.proximity >= cfg.near_level) ||
	                     (near_q && item_q.proximity < far_limit);

	assign sum = SUM_W'(item_q.up_count) + SUM_W'(item_q.down_count) +
	             SUM_W'(item_q.left_count) + SUM_W'(item_q.right_count);

	// end of run classification
	assign dv       = DELTA_W'(last_v_q) - DELTA_W'(first_v_q);
	assign dh       = DELTA_W'(last_h_q) - DELTA_W'(first_h_q);
	assign mv       = CMP_W'(dv[DELTA_W-1] ? -dv : dv);
	assign mh       = CMP_W'(dh[DELTA_W-1] ? -dh : dh);
	assign th       = CMP_W'(cfg.swipe_threshold);
	assign hit      = (mv > th) || (mh > th);
	assign gest     = (mv > mh) ? ((!dv[DELTA_W-1] && dv != '0) ? SW_UP : SW_DOWN)
	                            : ((!dh[DELTA_W-1] && dh != '0) ? SW_LEFT : SW_RIGHT);
	assign gest_rot = swg_rotate(gest, cfg.quarter_turns);

	assign div_a = cmd.sel_h ? item_q.left_count  : item_q.up_count;
	assign div_b = cmd.sel_h ? item_q.right_count : item_q.down_count;

	swg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.a      (div_a),
		.b      (div_b),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign push = cmd.prox_apply || (cmd.end_apply && hit);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item_in;
		end
		if (cmd.save_v) begin
			v_q <= div_quot;
		end
		// only a word that raises a result may touch the output register
		if (cmd.prox_apply) begin
			res_q <= '{event_kind: KIND_PROX, is_near: !near_q, swipe: PROX_SWIPE};
		end else if (push) begin
			res_q <= '{event_kind: KIND_GESTURE, is_near: near_q, swipe: gest_rot};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q       <= 1'b0;
			run_q        <= 1'b0;
			first_seen_q <= 1'b0;
			first_v_q    <= '0;
			first_h_q    <= '0;
			last_v_q     <= '0;
			last_h_q     <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.prox_apply) begin
				near_q <= !near_q;
			end
			if (cmd.commit) begin
				if (!first_seen_q) begin
					first_v_q <= v_q;
					first_h_q <= div_quot;
				end
				first_seen_q <= 1'b1;
				last_v_q     <= v_q;
				last_h_q     <= div_quot;
				run_q        <= 1'b1;
			end else if (cmd.end_apply) begin
				run_q        <= 1'b0;
				first_seen_q <= 1'b0;
			end
			if (push) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign status.action      = item_q.action;
	assign status.faint       = sum < SUM_W'(cfg.min_strength);
	assign status.prox_change = prox_change;
	assign status.run_active  = run_q;
	assign status.swipe_hit   = hit;
	assign status.slot_free   = !res_valid_q || res_ready;
	assign status.div_done    = div_done;
endmodule

// ===== rtl/swg_ctrl.sv =====
// swg_ctrl: sequencer of the classifier, one word at a time
// issues swg_cmd_t to swg_datapath from swg_status_t; depends on swg_pkg

module swg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  swg_pkg::swg_status_t status,
	output swg_pkg::swg_cmd_t    cmd
);
	import swg_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_DIV_V = 2'd2;
	localparam logic [1:0] S_DIV_H = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (status.action)
					ACT_PROX: begin
						if (!status.prox_change) begin
							state_d = S_IDLE;
						end else if (status.slot_free) begin
							cmd.prox_apply = 1'b1;
							state_d        = S_IDLE;
						end
					end
					ACT_DATASET: begin
						if (status.faint) begin
							state_d = S_IDLE;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV_V;
						end
					end
					ACT_IDLE: begin
						if (!status.run_active) begin
							state_d = S_IDLE;
						end else if (!status.swipe_hit || status.slot_free) begin
							cmd.end_apply = 1'b1;
							state_d       = S_IDLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_DIV_V: begin
				if (status.div_done) begin
					cmd.save_v    = 1'b1;
					cmd.div_start = 1'b1;
					cmd.sel_h     = 1'b1;
					state_d       = S_DIV_H;
				end
			end
			S_DIV_H: begin
				cmd.sel_h = 1'b1;
				if (status.div_done) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/swipe_gesture_classifier_core.sv =====
// swipe_gesture_classifier_core: top level with apb register file, sequencer and datapath
// depends on swg_pkg, swg_item_if, swg_result_if, swg_ctrl, swg_datapath

// Classifies words from a four-photodiode proximity and gesture sensor. A proximity
// word (action 0) runs a near/far flag with hysteresis and reports each change; a
// gesture dataset (action 1) whose count sum reaches min_strength yields two signed
// balance ratios, of which the first and the last of the run are kept; an idle word
// (action 2) ends the run and reports a swipe if a ratio delta beats swipe_threshold,
// rotated clockwise by quarter_turns. Words are taken one at a time. A strong
// dataset goes through the one bit-serial divider, which works out the vertical and
// then the horizontal ratio, one quotient bit per cycle, in Q1.15 at the default.
// Results sit in an output register, so the next word is taken while one waits; a
// word that would raise a second result holds in execute until the first has been
// taken. Registers are to be written over apb only while the block is idle; the
// block itself does not enforce this. Reads return the current values, pready is
// tied high.

module swipe_gesture_classifier_core (
	input  logic                           clk,
	input  logic                           arst_n,
	swg_item_if.sink                       item,
	swg_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [swg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [swg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [swg_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import swg_pkg::*;

	// configuration registers
	logic [NEAR_TH_W-1:0]  near_level_q;
	logic [TURNS_W-1:0]    quarter_turns_q;
	logic [SWIPE_TH_W-1:0] swipe_threshold_q;
	logic [STRENGTH_W-1:0] min_strength_q;

	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	swg_cfg_t    cfg;
	swg_item_t   item_word;
	swg_cmd_t    cmd;
	swg_status_t status;
	swg_result_t res;
	logic        res_valid;
	logic        item_ready;

	// apb: write at the access phase, word-aligned register index
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2 +: REG_IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_level_q      <= NEAR_TH_RST;
			quarter_turns_q   <= TURNS_RST;
			swipe_threshold_q <= SWIPE_TH_RST;
			min_strength_q    <= STRENGTH_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NEAR_LEVEL:      near_level_q      <= pwdata[NEAR_TH_W-1:0];
				REG_QUARTER_TURNS:   quarter_turns_q   <= pwdata[TURNS_W-1:0];
				REG_SWIPE_THRESHOLD: swipe_threshold_q <= pwdata[SWIPE_TH_W-1:0];
				REG_MIN_STRENGTH:    min_strength_q    <= pwdata[STRENGTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read back, zero-extended
	always_comb begin
		case (reg_idx)
			REG_NEAR_LEVEL:      prdata = APB_DATA_W'(near_level_q);
			REG_QUARTER_TURNS:   prdata = APB_DATA_W'(quarter_turns_q);
			REG_SWIPE_THRESHOLD: prdata = APB_DATA_W'(swipe_threshold_q);
			REG_MIN_STRENGTH:    prdata = APB_DATA_W'(min_strength_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.near_level      = near_level_q;
	assign cfg.quarter_turns   = quarter_turns_q;
	assign cfg.swipe_threshold = swipe_threshold_q;
	assign cfg.min_strength    = min_strength_q;

	// input word into the datapath word register
	assign item_word.action      = item.action;
	assign item_word.proximity   = item.proximity;
	assign item_word.up_count    = item.up_count;
	assign item_word.down_count  = item.down_count;
	assign item_word.left_count  = item.left_count;
	assign item_word.right_count = item.right_count;
	assign item.ready            = item_ready;

	swg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	swg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item_in   (item_word),
		.cmd       (cmd),
		.res_ready (result.ready),
		.res_valid (res_valid),
		.res       (res),
		.status    (status)
	);

	// result word straight from the output register
	assign result.valid      = res_valid;
	assign result.event_kind = res.event_kind;
	assign result.is_near    = res.is_near;
	assign result.swipe      = res.swipe;
endmodule
